[rtl/registration_request_tracker_core_defines.svh]
// Assertion macros shared by the tracker RTL.
`ifndef REGISTRATION_REQUEST_TRACKER_CORE_DEFINES_SVH
`define REGISTRATION_REQUEST_TRACKER_CORE_DEFINES_SVH

// Checked property, quiet while reset is applied.
`define RRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property, also checked while reset is applied.
`define RRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/rrt_pkg.sv]
// Types, codes and helpers of the registration request tracker.
`timescale 1ns / 1ps
`default_nettype none
package rrt_pkg;

  localparam int unsigned SlotsDef  = 16;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned SeqW      = 32;
  localparam int unsigned TickW     = 32;
  localparam int unsigned MpmW      = 5;
  localparam int unsigned AttW      = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned CntCmpW   = 8;
  localparam int unsigned QDepth    = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_PER_MSG  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_TMO    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ATTEMPTS = 2'd2;

  // Request kinds
  localparam logic [2:0] REQ_UPDATE  = 3'd0;
  localparam logic [2:0] REQ_SERVER  = 3'd1;
  localparam logic [2:0] REQ_COLLECT = 3'd2;
  localparam logic [2:0] REQ_CHECK   = 3'd3;
  localparam logic [2:0] REQ_REMOVE  = 3'd4;
  localparam logic [2:0] REQ_QUERY   = 3'd5;

  // Slot states
  localparam logic [2:0] ST_EMPTY      = 3'd0;
  localparam logic [2:0] ST_REG_PEND   = 3'd1;
  localparam logic [2:0] ST_UNREG_PEND = 3'd2;
  localparam logic [2:0] ST_REG_CONF   = 3'd3;
  localparam logic [2:0] ST_UNREG_CONF = 3'd4;

  // Notice codes
  localparam logic [2:0] CODE_SUCCESS   = 3'd0;
  localparam logic [2:0] CODE_TRANSIENT = 3'd1;
  localparam logic [2:0] CODE_STALE     = 3'd3;

  // Result kinds
  localparam logic [1:0] KIND_NOTICE  = 2'd0;
  localparam logic [1:0] KIND_OP      = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_ANSWER  = 2'd3;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [KeyW-1:0]  key;
    logic             op;
    logic [SeqW-1:0]  seq;
    logic             present;
    logic [2:0]       status;
    logic [TickW-1:0] now;
  } item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [KeyW-1:0] key;
    logic            op;
    logic [SeqW-1:0] seq;
    logic [2:0]      code;
    logic [2:0]      state;
    logic [MpmW-1:0] cnt;
    logic            data;
    logic            full;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [SeqW-1:0]  seq;
    logic [TickW-1:0] stime;
    logic [AttW-1:0]  att;
  } slot_t;

  function automatic logic is_pending(input logic [2:0] st);
    return (st == ST_REG_PEND) || (st == ST_UNREG_PEND);
  endfunction

  function automatic logic op_of(input logic [2:0] st);
    return (st == ST_UNREG_PEND) || (st == ST_UNREG_CONF);
  endfunction

endpackage
`default_nettype wire

[rtl/rrt_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module rrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/rrt_front.sv]
// Request intake: accepts, filters unknown kinds and queues words for the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "registration_request_tracker_core_defines.svh"
module rrt_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rrt_pkg::item_t item_i,
  output logic               busy_o,
  output logic               item_valid_o,
  output rrt_pkg::item_t     item_o,
  input  wire logic          item_ready_i
);

  rrt_pkg::item_t q_q [rrt_pkg::QDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  // Unknown request kinds are taken and dropped
  assign busy_o       = (cnt_q == 2'(rrt_pkg::QDepth));
  assign push         = start_i && !busy_o && (item_i.req_type <= rrt_pkg::REQ_QUERY);
  assign pop          = (cnt_q != 2'd0) && item_ready_i;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_q[rd_ptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= item_i;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `RRT_ASSERT(a_q_bound, (cnt_q <= 2'(rrt_pkg::QDepth)), "queue overfilled")
  `RRT_ASSERT(a_q_push, (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1), "push lost")

endmodule
`default_nettype wire

[rtl/rrt_back.sv]
// Execution end: walks the slot table per request and emits result words.
`timescale 1ns / 1ps
`default_nettype none
`include "registration_request_tracker_core_defines.svh"
module rrt_back #(
  parameter int unsigned SLOTS = rrt_pkg::SlotsDef,
  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned CW   = $clog2(SLOTS + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        item_valid_i,
  input  wire rrt_pkg::item_t              item_i,
  output logic                             item_ready_o,
  input  wire logic [rrt_pkg::MpmW-1:0]    max_per_msg_i,
  input  wire logic [rrt_pkg::TickW-1:0]   retry_tmo_i,
  input  wire logic [rrt_pkg::AttW-1:0]    max_att_i,
  output logic                             res_valid_o,
  output rrt_pkg::res_t                    res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } bk_state_e;

  bk_state_e state_q, state_d;
  rrt_pkg::item_t req_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]    st_q [SLOTS];
  logic [2:0]    st_d [SLOTS];
  logic          sent_q [SLOTS];
  logic          sent_d [SLOTS];
  logic          found_q, found_d, efound_q, efound_d;
  logic [IW-1:0] fidx_q, fidx_d, eidx_q, eidx_d;
  logic [rrt_pkg::SeqW-1:0] fseq_q, fseq_d, seqc_q, seqc_d;
  logic [2:0]    fst_q, fst_d;
  logic [CW-1:0] ccnt_q, ccnt_d;
  logic          data_q, data_d;
  rrt_pkg::res_t res_q, res_d;
  logic          res_valid_q, res_valid_d;

  logic          we;
  logic [IW-1:0] waddr, raddr, a;
  logic [CW-1:0] a_full;
  rrt_pkg::slot_t wdata, rd;
  logic [2:0]    cur_st;
  logic          pend;
  logic [rrt_pkg::TickW:0] due;

  // Key, sequence, send time and attempts per slot
  rrt_ram #(.WIDTH($bits(rrt_pkg::slot_t)), .DEPTH(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  assign item_ready_o = (state_q == S_IDLE);
  assign raddr  = (cnt_q < CW'(SLOTS)) ? cnt_q[IW-1:0] : '0;
  assign a_full = cnt_q - CW'(1);
  assign a      = a_full[IW-1:0];
  assign cur_st = st_q[a];
  assign pend   = rrt_pkg::is_pending(cur_st);
  assign due    = {1'b0, rd.stime} + {1'b0, retry_tmo_i};

  // Scan and finish sequencing
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    st_d        = st_q;
    sent_d      = sent_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    fseq_d      = fseq_q;
    fst_d       = fst_q;
    efound_d    = efound_q;
    eidx_d      = eidx_q;
    ccnt_d      = ccnt_q;
    data_d      = data_q;
    seqc_d      = seqc_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    we          = 1'b0;
    waddr       = a;
    wdata       = rd;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          cnt_d    = '0;
          found_d  = 1'b0;
          efound_d = 1'b0;
          ccnt_d   = '0;
          data_d   = 1'b0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(SLOTS)) state_d = S_FIN;
        if (cnt_q != '0) begin
          case (req_q.req_type)
            rrt_pkg::REQ_UPDATE, rrt_pkg::REQ_SERVER, rrt_pkg::REQ_QUERY: begin
              if (cur_st != rrt_pkg::ST_EMPTY && rd.key == req_q.key && !found_q) begin
                found_d = 1'b1;
                fidx_d  = a;
                fseq_d  = rd.seq;
                fst_d   = cur_st;
              end
              if (cur_st == rrt_pkg::ST_EMPTY && !efound_q) begin
                efound_d = 1'b1;
                eidx_d   = a;
              end
            end
            rrt_pkg::REQ_COLLECT: begin
              if (pend && !sent_q[a] &&
                  (rrt_pkg::CntCmpW'(ccnt_q) < rrt_pkg::CntCmpW'(max_per_msg_i))) begin
                sent_d[a]   = 1'b1;
                we          = 1'b1;
                wdata.stime = req_q.now;
                ccnt_d      = ccnt_q + CW'(1);
                res_valid_d = 1'b1;
                res_d.kind  = rrt_pkg::KIND_OP;
                res_d.key   = rd.key;
                res_d.op    = rrt_pkg::op_of(cur_st);
                res_d.seq   = rd.seq;
              end
            end
            rrt_pkg::REQ_CHECK: begin
              if (pend) begin
                if (!sent_q[a]) begin
                  data_d = 1'b1;
                end else if (due <= {1'b0, req_q.now}) begin
                  if (rd.att == max_att_i) begin
                    st_d[a]     = rrt_pkg::ST_EMPTY;
                    res_valid_d = 1'b1;
                    res_d.kind  = rrt_pkg::KIND_NOTICE;
                    res_d.key   = rd.key;
                    res_d.op    = rrt_pkg::op_of(cur_st);
                    res_d.seq   = rd.seq;
                    res_d.code  = rrt_pkg::CODE_TRANSIENT;
                  end else begin
                    we        = 1'b1;
                    wdata.att = rd.att + rrt_pkg::AttW'(1);
                    sent_d[a] = 1'b0;
                    data_d    = 1'b1;
                  end
                end
              end
            end
            rrt_pkg::REQ_REMOVE: begin
              if (pend) begin
                res_valid_d = 1'b1;
                res_d.kind  = rrt_pkg::KIND_NOTICE;
                res_d.key   = rd.key;
                res_d.op    = rrt_pkg::op_of(cur_st);
                res_d.seq   = rd.seq;
                res_d.code  = rrt_pkg::CODE_TRANSIENT;
              end
              st_d[a] = rrt_pkg::ST_EMPTY;
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
        case (req_q.req_type)
          rrt_pkg::REQ_UPDATE: begin
            // open a new pending record at waddr when we is set below
            if (found_q && rrt_pkg::is_pending(fst_q)) begin
              res_valid_d = 1'b1;
              res_d.key   = req_q.key;
              res_d.op    = rrt_pkg::op_of(fst_q);
              res_d.seq   = fseq_q;
              res_d.code  = rrt_pkg::CODE_STALE;
              if (rrt_pkg::op_of(fst_q) != req_q.op) begin
                we    = 1'b1;
                waddr = fidx_q;
              end
            end else if (found_q) begin
              if (rrt_pkg::op_of(fst_q) == req_q.op) begin
                res_valid_d = 1'b1;
                res_d.key   = req_q.key;
                res_d.op    = req_q.op;
                res_d.seq   = fseq_q;
                res_d.code  = rrt_pkg::CODE_SUCCESS;
              end else begin
                we    = 1'b1;
                waddr = fidx_q;
              end
            end else if (efound_q) begin
              we    = 1'b1;
              waddr = eidx_q;
            end else begin
              res_valid_d = 1'b1;
              res_d.key   = req_q.key;
              res_d.op    = req_q.op;
              res_d.code  = rrt_pkg::CODE_TRANSIENT;
              res_d.full  = 1'b1;
            end
            if (we) begin
              seqc_d        = seqc_q + rrt_pkg::SeqW'(1);
              st_d[waddr]   = req_q.op ? rrt_pkg::ST_UNREG_PEND : rrt_pkg::ST_REG_PEND;
              sent_d[waddr] = 1'b0;
              wdata.key     = req_q.key;
              wdata.seq     = seqc_q + rrt_pkg::SeqW'(1);
              wdata.stime   = '0;
              wdata.att     = rrt_pkg::AttW'(1);
            end
          end
          rrt_pkg::REQ_SERVER: begin
            if (req_q.present && found_q && rrt_pkg::is_pending(fst_q) &&
                fseq_q == req_q.seq && rrt_pkg::op_of(fst_q) == req_q.op) begin
              res_valid_d = 1'b1;
              res_d.key   = req_q.key;
              res_d.op    = req_q.op;
              res_d.seq   = req_q.seq;
              res_d.code  = req_q.status;
              if (req_q.status == rrt_pkg::CODE_SUCCESS) begin
                st_d[fidx_q] = req_q.op ? rrt_pkg::ST_UNREG_CONF : rrt_pkg::ST_REG_CONF;
              end else begin
                st_d[fidx_q] = rrt_pkg::ST_EMPTY;
              end
            end
          end
          rrt_pkg::REQ_COLLECT: begin
            res_valid_d = 1'b1;
            res_d.kind  = rrt_pkg::KIND_SUMMARY;
            res_d.cnt   = rrt_pkg::MpmW'(ccnt_q);
          end
          rrt_pkg::REQ_CHECK: begin
            res_valid_d = 1'b1;
            res_d.kind  = rrt_pkg::KIND_SUMMARY;
            res_d.data  = data_q;
          end
          rrt_pkg::REQ_REMOVE: begin
            res_valid_d = 1'b1;
            res_d.kind  = rrt_pkg::KIND_SUMMARY;
          end
          rrt_pkg::REQ_QUERY: begin
            res_valid_d = 1'b1;
            res_d.kind  = rrt_pkg::KIND_ANSWER;
            res_d.key   = req_q.key;
            if (found_q) begin
              res_d.op    = rrt_pkg::op_of(fst_q);
              res_d.seq   = fseq_q;
              res_d.state = fst_q;
            end
          end
          default: ;
        endcase
        res_d.last = res_valid_d;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Request and scan payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && item_valid_i) req_q <= item_i;
    fidx_q <= fidx_d;
    fseq_q <= fseq_d;
    fst_q  <= fst_d;
    eidx_q <= eidx_d;
    res_q  <= res_d;
  end

  // Control and slot status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      efound_q    <= 1'b0;
      ccnt_q      <= '0;
      data_q      <= 1'b0;
      seqc_q      <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        st_q[i]   <= rrt_pkg::ST_EMPTY;
        sent_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      efound_q    <= efound_d;
      ccnt_q      <= ccnt_d;
      data_q      <= data_d;
      seqc_q      <= seqc_d;
      res_valid_q <= res_valid_d;
      st_q        <= st_d;
      sent_q      <= sent_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `RRT_ASSERT(a_state_onehot, $onehot(state_q), "back state not one-hot")
  `RRT_ASSERT(a_idle_quiet, (state_q == S_IDLE) |=> !res_valid_q, "word out of idle")
  `RRT_ASSERT(a_summary_last, (state_q == S_FIN && (req_q.req_type == rrt_pkg::REQ_COLLECT || req_q.req_type == rrt_pkg::REQ_CHECK || req_q.req_type == rrt_pkg::REQ_REMOVE)) |=> (res_valid_q && res_q.last), "summary missing")
  `RRT_ASSERT(a_collect_cap, (rrt_pkg::CntCmpW'(ccnt_q) <= rrt_pkg::CntCmpW'(max_per_msg_i)) || (req_q.req_type != rrt_pkg::REQ_COLLECT) || (state_q == S_IDLE), "collect over cap")

endmodule
`default_nettype wire

[rtl/registration_request_tracker_core.sv]
// Top level of the registration request tracker: configuration, intake and execution.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low; up to two requests wait in an
// intake queue while the execution end works. Each request passes the execution end
// in order: load, a walk of every slot of the table through the registered read of the
// slot memory, and a finish state. Result words appear on the out_* ports for one cycle
// each with out_valid_o, one per cycle at most; there is no backpressure, so the
// receiver must take every word as it comes. last_o marks the final word of a request;
// updates that open a record give no word unless they replace a pending one (a stale
// notice), and ignored server results and unknown request kinds give no word.
module registration_request_tracker_core #(
  parameter int unsigned SLOTS = rrt_pkg::SlotsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    req_type_i,
  input  wire logic [rrt_pkg::KeyW-1:0]      object_key_i,
  input  wire logic                          op_kind_i,
  input  wire logic [rrt_pkg::SeqW-1:0]      seq_in_i,
  input  wire logic                          status_present_i,
  input  wire logic [2:0]                    status_in_i,
  input  wire logic [rrt_pkg::TickW-1:0]     now_tick_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rrt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rrt_pkg::CfgW-1:0]      cfg_wdata_i,
  output logic                               out_valid_o,
  output logic [1:0]                         out_kind_o,
  output logic [rrt_pkg::KeyW-1:0]           out_key_o,
  output logic                               out_op_o,
  output logic [rrt_pkg::SeqW-1:0]           out_seq_o,
  output logic [2:0]                         notice_code_o,
  output logic [2:0]                         reg_state_o,
  output logic [rrt_pkg::MpmW-1:0]           sent_count_o,
  output logic                               has_data_o,
  output logic                               table_full_o,
  output logic                               last_o
);

  logic [rrt_pkg::MpmW-1:0]  max_per_msg_q;
  logic [rrt_pkg::TickW-1:0] retry_tmo_q;
  logic [rrt_pkg::AttW-1:0]  max_att_q;
  rrt_pkg::item_t in_item, q_item;
  rrt_pkg::res_t  res;
  logic           q_valid, q_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_per_msg_q <= rrt_pkg::MpmW'(8);
      retry_tmo_q   <= rrt_pkg::TickW'(1000);
      max_att_q     <= rrt_pkg::AttW'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rrt_pkg::CFG_MAX_PER_MSG:  max_per_msg_q <= cfg_wdata_i[rrt_pkg::MpmW-1:0];
        rrt_pkg::CFG_RETRY_TMO:    retry_tmo_q   <= cfg_wdata_i[rrt_pkg::TickW-1:0];
        rrt_pkg::CFG_MAX_ATTEMPTS: max_att_q     <= cfg_wdata_i[rrt_pkg::AttW-1:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{req_type: req_type_i, key: object_key_i, op: op_kind_i,
                     seq: seq_in_i, present: status_present_i, status: status_in_i,
                     now: now_tick_i};

  rrt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .item_i       (in_item),
    .busy_o       (busy),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_ready_i (q_ready)
  );

  rrt_back #(.SLOTS(SLOTS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_ready_o  (q_ready),
    .max_per_msg_i (max_per_msg_q),
    .retry_tmo_i   (retry_tmo_q),
    .max_att_i     (max_att_q),
    .res_valid_o   (out_valid_o),
    .res_o         (res)
  );

  // Result word fields
  assign out_kind_o    = res.kind;
  assign out_key_o     = res.key;
  assign out_op_o      = res.op;
  assign out_seq_o     = res.seq;
  assign notice_code_o = res.code;
  assign reg_state_o   = res.state;
  assign sent_count_o  = res.cnt;
  assign has_data_o    = res.data;
  assign table_full_o  = res.full;
  assign last_o        = res.last;

endmodule
`default_nettype wire

[tb/sv/registration_request_tracker_core_test.sv]
// Self-checking testbench of the registration request tracker core.
`timescale 1ns / 1ps
module registration_request_tracker_core_test;
  import rrt_pkg::*;

  localparam int NSLOT = 16;
  localparam int DRAIN_CYCLES = 60;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [2:0]          req_type_i = '0;
  logic [KeyW-1:0]     object_key_i = '0;
  logic                op_kind_i = 1'b0;
  logic [SeqW-1:0]     seq_in_i = '0;
  logic                status_present_i = 1'b0;
  logic [2:0]          status_in_i = '0;
  logic [TickW-1:0]    now_tick_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                out_valid_o;
  logic [1:0]          out_kind_o;
  logic [KeyW-1:0]     out_key_o;
  logic                out_op_o;
  logic [SeqW-1:0]     out_seq_o;
  logic [2:0]          notice_code_o;
  logic [2:0]          reg_state_o;
  logic [MpmW-1:0]     sent_count_o;
  logic                has_data_o;
  logic                table_full_o;
  logic                last_o;

  registration_request_tracker_core u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .object_key_i, .op_kind_i, .seq_in_i,
    .status_present_i, .status_in_i, .now_tick_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .out_valid_o, .out_kind_o, .out_key_o, .out_op_o, .out_seq_o, .notice_code_o,
    .reg_state_o, .sent_count_o, .has_data_o, .table_full_o, .last_o
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the tracker table and its registers
  logic [2:0]       trk_state [NSLOT];
  logic [KeyW-1:0]  trk_key   [NSLOT];
  logic [SeqW-1:0]  trk_seq   [NSLOT];
  logic             trk_sent  [NSLOT];
  logic [TickW-1:0] trk_stime [NSLOT];
  logic [AttW-1:0]  trk_att   [NSLOT];
  logic [SeqW-1:0]  trk_seqc;
  logic [MpmW-1:0]  trk_mpm;
  logic [31:0]      trk_tmo;
  logic [AttW-1:0]  trk_matt;

  res_t            expected_words [$];
  int              errors = 0;
  int              idle_pct = 0;
  logic [TickW-1:0] tick = '0;
  logic [KeyW-1:0] key_pool [24];

  task automatic report(input string what, input logic [KeyW-1:0] got,
                        input logic [KeyW-1:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic int find_slot(input logic [KeyW-1:0] key);
    for (int i = 0; i < NSLOT; i++)
      if (trk_state[i] != ST_EMPTY && trk_key[i] == key) return i;
    return -1;
  endfunction

  function automatic logic slot_op(input logic [2:0] st);
    return (st == ST_UNREG_PEND) || (st == ST_UNREG_CONF);
  endfunction

  function automatic logic slot_pend(input logic [2:0] st);
    return (st == ST_REG_PEND) || (st == ST_UNREG_PEND);
  endfunction

  task automatic push_word(input logic [1:0] kind, input logic [KeyW-1:0] key,
                           input logic op, input logic [SeqW-1:0] seq,
                           input logic [2:0] code, input logic [2:0] st,
                           input logic [MpmW-1:0] cnt, input logic data,
                           input logic full);
    res_t w;
    w = '{kind: kind, key: key, op: op, seq: seq, code: code, state: st, cnt: cnt,
          data: data, full: full, last: 1'b0};
    expected_words.push_back(w);
  endtask

  task automatic open_record(input int i, input logic [KeyW-1:0] key, input logic op);
    trk_seqc++;
    trk_state[i] = op ? ST_UNREG_PEND : ST_REG_PEND;
    trk_key[i] = key;
    trk_seq[i] = trk_seqc;
    trk_sent[i] = 1'b0;
    trk_stime[i] = '0;
    trk_att[i] = 1;
  endtask

  task automatic abort_record(input int i);
    push_word(KIND_NOTICE, trk_key[i], slot_op(trk_state[i]), trk_seq[i], CODE_TRANSIENT,
              ST_EMPTY, 0, 1'b0, 1'b0);
    trk_state[i] = ST_EMPTY;
  endtask

  // Work out the words one accepted request gives
  task automatic predict_words(input item_t it);
    int i;
    int n0;
    logic [MpmW-1:0] cnt;
    logic data;
    n0 = expected_words.size();
    case (it.req_type)
      REQ_UPDATE: begin
        i = find_slot(it.key);
        if (i >= 0 && slot_pend(trk_state[i])) begin
          push_word(KIND_NOTICE, it.key, slot_op(trk_state[i]), trk_seq[i], CODE_STALE,
                    ST_EMPTY, 0, 1'b0, 1'b0);
          if (slot_op(trk_state[i]) != it.op) open_record(i, it.key, it.op);
        end else if (i >= 0) begin
          if (slot_op(trk_state[i]) == it.op)
            push_word(KIND_NOTICE, it.key, it.op, trk_seq[i], CODE_SUCCESS, ST_EMPTY, 0,
                      1'b0, 1'b0);
          else open_record(i, it.key, it.op);
        end else begin
          for (i = 0; i < NSLOT; i++) if (trk_state[i] == ST_EMPTY) break;
          if (i < NSLOT) open_record(i, it.key, it.op);
          else push_word(KIND_NOTICE, it.key, it.op, '0, CODE_TRANSIENT, ST_EMPTY, 0,
                         1'b0, 1'b1);
        end
      end
      REQ_SERVER: if (it.present) begin
        i = find_slot(it.key);
        if (i >= 0 && slot_pend(trk_state[i]) && trk_seq[i] == it.seq &&
            slot_op(trk_state[i]) == it.op) begin
          push_word(KIND_NOTICE, it.key, it.op, it.seq, it.status, ST_EMPTY, 0, 1'b0, 1'b0);
          if (it.status == CODE_SUCCESS) trk_state[i] = it.op ? ST_UNREG_CONF : ST_REG_CONF;
          else trk_state[i] = ST_EMPTY;
        end
      end
      REQ_COLLECT: begin
        cnt = '0;
        for (i = 0; i < NSLOT && cnt < trk_mpm; i++)
          if (slot_pend(trk_state[i]) && !trk_sent[i]) begin
            trk_sent[i] = 1'b1;
            trk_stime[i] = it.now;
            cnt++;
            push_word(KIND_OP, trk_key[i], slot_op(trk_state[i]), trk_seq[i], '0, ST_EMPTY,
                      0, 1'b0, 1'b0);
          end
        push_word(KIND_SUMMARY, '0, 1'b0, '0, '0, ST_EMPTY, cnt, 1'b0, 1'b0);
      end
      REQ_CHECK: begin
        data = 1'b0;
        for (i = 0; i < NSLOT; i++) begin
          if (!slot_pend(trk_state[i])) continue;
          if (!trk_sent[i]) begin
            data = 1'b1;
            continue;
          end
          if ({1'b0, trk_stime[i]} + {1'b0, trk_tmo} > {1'b0, it.now}) continue;
          if (trk_att[i] == trk_matt) abort_record(i);
          else begin
            trk_att[i]++;
            trk_sent[i] = 1'b0;
            data = 1'b1;
          end
        end
        push_word(KIND_SUMMARY, '0, 1'b0, '0, '0, ST_EMPTY, 0, data, 1'b0);
      end
      REQ_REMOVE: begin
        for (i = 0; i < NSLOT; i++) begin
          if (slot_pend(trk_state[i])) abort_record(i);
          trk_state[i] = ST_EMPTY;
        end
        push_word(KIND_SUMMARY, '0, 1'b0, '0, '0, ST_EMPTY, 0, 1'b0, 1'b0);
      end
      REQ_QUERY: begin
        i = find_slot(it.key);
        if (i >= 0)
          push_word(KIND_ANSWER, it.key, slot_op(trk_state[i]), trk_seq[i], '0,
                    trk_state[i], 0, 1'b0, 1'b0);
        else push_word(KIND_ANSWER, it.key, 1'b0, '0, '0, ST_EMPTY, 0, 1'b0, 1'b0);
      end
      default: ;
    endcase
    if (expected_words.size() > n0) expected_words[$].last = 1'b1;
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni && out_valid_o) begin
      if (expected_words.size() == 0) begin
        $display("unexpected word kind %0d key %0h", out_kind_o, out_key_o);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_kind_o != w.kind) report("kind", out_kind_o, w.kind);
        if (out_key_o != w.key) report("key", out_key_o, w.key);
        if (out_op_o != w.op) report("op", out_op_o, w.op);
        if (out_seq_o != w.seq) report("seq", out_seq_o, w.seq);
        if (notice_code_o != w.code) report("code", notice_code_o, w.code);
        if (reg_state_o != w.state) report("state", reg_state_o, w.state);
        if (sent_count_o != w.cnt) report("count", sent_count_o, w.cnt);
        if (has_data_o != w.data) report("has_data", has_data_o, w.data);
        if (table_full_o != w.full) report("full", table_full_o, w.full);
        if (last_o != w.last) report("last", last_o, w.last);
      end
    end
  end

  function automatic item_t mk(input logic [2:0] req, input logic [KeyW-1:0] key,
                               input logic op, input logic [SeqW-1:0] seq,
                               input logic pres, input logic [2:0] status,
                               input logic [TickW-1:0] now);
    item_t it;
    it = '{req_type: req, key: key, op: op, seq: seq, present: pres, status: status,
           now: now};
    return it;
  endfunction

  // Send one request word; start stays high into the next word unless a gap follows
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= it.req_type;
    object_key_i <= it.key;
    op_kind_i <= it.op;
    seq_in_i <= it.seq;
    status_present_i <= it.present;
    status_in_i <= it.status;
    now_tick_i <= it.now;
    do @(posedge clk_i); while (busy);
    predict_words(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_PER_MSG:  trk_mpm = val[MpmW-1:0];
      CFG_RETRY_TMO:    trk_tmo = val;
      CFG_MAX_ATTEMPTS: trk_matt = val[AttW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int mpm, input logic [31:0] tmo, input int att);
    write_cfg(CFG_MAX_PER_MSG, mpm);
    write_cfg(CFG_RETRY_TMO, tmo);
    write_cfg(CFG_MAX_ATTEMPTS, att);
  endtask

  // Fill the table, overflow it, then walk every request kind
  task automatic test_directed();
    int i;
    for (i = 0; i < NSLOT; i++) send_item(mk(REQ_UPDATE, key_pool[i], i[0], '0, 0, 0, 0));
    send_item(mk(REQ_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0, 0, 0, 0));
    send_item(mk(REQ_QUERY, key_pool[3], 1'b0, '0, 0, 0, 0));
    send_item(mk(REQ_QUERY, 64'h5A5A_0000_DEAD_BEEF, 1'b1, '1, 1, 7, '1));
    // same kind on a pending key is stale only; other kind reopens
    send_item(mk(REQ_UPDATE, key_pool[0], 1'b0, '0, 0, 0, 0));
    send_item(mk(REQ_UPDATE, key_pool[1], 1'b0, '0, 0, 0, 0));
    send_item(mk(REQ_COLLECT, '0, 1'b0, '0, 0, 0, 32'd100));
    send_item(mk(REQ_COLLECT, '0, 1'b0, '0, 0, 0, 32'd200));
    send_item(mk(REQ_SERVER, key_pool[2], 1'b0, trk_seq[2], 1'b0, 0, 0));
    send_item(mk(REQ_SERVER, key_pool[2], 1'b0, trk_seq[2] + 1, 1'b1, 0, 0));
    send_item(mk(REQ_SERVER, key_pool[2], 1'b0, trk_seq[2], 1'b1, CODE_SUCCESS, 0));
    send_item(mk(REQ_SERVER, key_pool[3], 1'b1, trk_seq[3], 1'b1, 3'd2, 0));
    // confirmed key: same kind answers success, other kind reopens
    send_item(mk(REQ_UPDATE, key_pool[2], 1'b0, '0, 0, 0, 0));
    send_item(mk(REQ_UPDATE, key_pool[2], 1'b1, '0, 0, 0, 0));
    send_item(mk(REQ_CHECK, '0, 1'b0, '0, 0, 0, 32'd1100));
    send_item(mk(REQ_CHECK, '0, 1'b0, '0, 0, 0, '1));
    send_item(mk(3'd6, '1, 1'b1, '1, 1, 7, '1));
    send_item(mk(3'd7, '0, 1'b0, '0, 0, 0, 0));
    send_item(mk(REQ_REMOVE, '0, 1'b0, '0, 0, 0, 0));
    wait_idle();
  endtask

  // Mostly well-formed traffic over a small key pool, with some noise
  function automatic item_t random_item();
    item_t it;
    int r;
    int i;
    int cand [$];
    r = $urandom_range(99);
    it = mk(REQ_QUERY, key_pool[$urandom_range(23)], $urandom_range(1), $urandom,
            $urandom_range(1), $urandom_range(7), tick);
    if ($urandom_range(19) == 0) it.now = $urandom;
    if (r < 35) it.req_type = REQ_UPDATE;
    else if (r < 60) begin
      it.req_type = REQ_SERVER;
      for (i = 0; i < NSLOT; i++) if (slot_pend(trk_state[i])) cand.push_back(i);
      if (cand.size() > 0 && $urandom_range(9) < 8) begin
        i = cand[$urandom_range(cand.size() - 1)];
        it.key = trk_key[i];
        it.op = slot_op(trk_state[i]);
        it.seq = trk_seq[i];
        it.present = $urandom_range(9) != 0;
        it.status = $urandom_range(1) ? CODE_SUCCESS : 3'($urandom_range(7));
      end
    end else if (r < 72) it.req_type = REQ_COLLECT;
    else if (r < 86) it.req_type = REQ_CHECK;
    else if (r < 89) it.req_type = REQ_REMOVE;
    else if (r < 97) it.req_type = REQ_QUERY;
    else begin
      it.req_type = 3'($urandom_range(6, 7));
      it.key = {$urandom, $urandom};
    end
    return it;
  endfunction

  task automatic test_random(input int count, input int gap_pct);
    idle_pct = gap_pct;
    for (int n = 0; n < count; n++) begin
      tick = tick + $urandom_range(0, 600);
      send_item(random_item());
    end
    wait_idle();
  endtask

  // Extreme register settings: single-record messages and instant aborts
  task automatic test_config_low();
    set_config(1, 32'd1, 1);
    test_random(50, 16);
  endtask

  task automatic test_config_high();
    set_config(16, 32'hFFFF_FFFF, 15);
    test_random(50, 45);
  endtask

  task automatic test_config_mid();
    set_config(5, 32'd300, 15);
    test_random(70, 0);
    set_config(8, 32'd50, 2);
    test_random(60, 16);
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      trk_state[i] = ST_EMPTY;
      trk_key[i] = '0;
      trk_seq[i] = '0;
      trk_sent[i] = 1'b0;
      trk_stime[i] = '0;
      trk_att[i] = '0;
    end
    trk_seqc = '0;
    trk_mpm = 5'd8;
    trk_tmo = 32'd1000;
    trk_matt = 4'd3;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 24; i++) key_pool[i] = {$urandom, $urandom};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    idle_pct = 16;
    test_directed();
    test_config_low();
    test_config_high();
    test_config_mid();
    if (errors == 0) $display("PASS registration_request_tracker_core");
    else $display("FAIL registration_request_tracker_core");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL registration_request_tracker_core");
    $finish;
  end

endmodule
